// ----- hdl/bete_pkg.sv -----
// Shared constants and types for the bracket exit trade evaluator.
package bete_pkg;

    localparam logic [2:0] EXIT_GAP_STOP = 3'd0;
    localparam logic [2:0] EXIT_STOP     = 3'd1;
    localparam logic [2:0] EXIT_TARGET   = 3'd2;
    localparam logic [2:0] EXIT_TIME     = 3'd3;
    localparam logic [2:0] EXIT_INVALID  = 3'd4;

    localparam logic [1:0] CFG_STOP_MULT = 2'd0;
    localparam logic [1:0] CFG_HALF_MULT = 2'd1;
    localparam logic [1:0] CFG_RUN_MULT  = 2'd2;
    localparam logic [1:0] CFG_COST      = 2'd3;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic start;
        logic half;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hdl/bracket_exit_trade_evaluator.sv -----
// Top level of the bracket exit trade evaluator: bar sequencer and result register.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, bar fields            | request in
//  out     | out_valid, out_ready, result fields       | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// A skipped bar or a bar of a closed trade passes S_EVAL and S_LAST, a plain bar
// also S_RUNCHK and S_OUT. A half take, a stop or target exit and a time exit
// each add one bit-serial division, a first bar adds the target multiplications
// S_TGT_H and S_TGT_R and a last bar adds S_NET. Reset clears the trade flags,
// levels and returns and restores the register defaults.
// The result register frees the sequencer; a last bar stalls only while the
// previous result still waits.
module bracket_exit_trade_evaluator #(
    parameter int PRICE_WIDTH      = 32,
    parameter int RETURN_FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        first_bar,
    input  logic        last_bar,
    input  logic [31:0] entry_price,
    input  logic [31:0] volatility,
    input  logic [31:0] bar_open,
    input  logic        open_ok,
    input  logic [31:0] bar_high,
    input  logic        high_ok,
    input  logic [31:0] bar_low,
    input  logic        low_ok,
    input  logic [31:0] bar_close,
    input  logic        close_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] net_return,
    output logic        trade_valid,
    output logic [2:0]  exit_kind,
    output logic        half_taken_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import bete_pkg::*;

    localparam int PW = PRICE_WIDTH;
    localparam int LW = PW + 9;
    localparam logic [LW-1:0] CAP = LW'(1) << (PW + 8);

    typedef enum logic [3:0] {
        S_IDLE, S_TGT_H, S_TGT_R, S_EVAL, S_HALF, S_RUNCHK, S_DIV,
        S_LAST, S_NET, S_OUT
    } state_t;

    typedef enum logic [1:0] { D_GAP, D_STOP, D_HALF, D_RUN } dkind_t;

    state_t state_reg;
    dkind_t dk_reg;
    logic [15:0] stop_mult_reg, half_mult_reg, run_mult_reg;
    logic [23:0] cost_reg;

    logic [PW-1:0] entry_reg;
    logic [PW-1:0] last_close_reg;
    logic signed [LW:0] stop_reg;
    logic [LW-1:0] half_reg, run_reg;
    logic half_flag_reg, exit_flag_reg, close_seen_reg, entry_bad_reg;
    logic signed [31:0] realized_reg, exit_ret_reg;
    logic [2:0] exit_code_reg;
    logic last_reg;
    logic [PW-1:0] open_reg, high_reg, low_reg;
    logic ook_reg, hok_reg, lok_reg;
    logic [PW+15:0] risk_reg;
    logic [PW+31:0] prod;
    logic [15:0] mul_sel;
    logic [LW:0] tsum;
    logic [LW-1:0] tgt;
    logic signed [32:0] ret_reg;
    logic res_ok_reg;
    logic [2:0] kind_reg;

    div_cmd_t  dcmd;
    div_stat_t dstat;
    logic [LW-1:0] dp8;
    logic signed [32:0] dratio;

    logic signed [32:0] sum_in;
    logic signed [33:0] sum_w;
    logic signed [31:0] sum_sat;
    logic signed [33:0] net_w;
    logic signed [31:0] net_sat;
    logic [LW-1:0] e8;
    logic time_exit;
    logic out_load;

    bete_ratio_div #(
        .PRICE_WIDTH(PRICE_WIDTH),
        .RETURN_FRAC_BITS(RETURN_FRAC_BITS)
    ) u_div (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .p8(dp8), .e(entry_reg),
        .stat(dstat), .ratio(dratio)
    );

    assign e8 = LW'(entry_reg) << 8;
    assign mul_sel = (state_reg == S_TGT_H) ? half_mult_reg : run_mult_reg;
    assign prod = 48'(0) + (PW+32)'(mul_sel) * (PW+32)'(risk_reg);
    assign tsum = (LW+1)'(e8) + (LW+1)'(prod >> 8);

    always_comb
    begin
        if ((prod >> 8) >= (PW+32)'(CAP) || tsum >= (LW+1)'(CAP))
        begin
            tgt = CAP;
        end
        else
        begin
            tgt = tsum[LW-1:0];
        end
    end

    assign time_exit = last_reg && !entry_bad_reg && entry_reg != '0 && !exit_flag_reg
                       && close_seen_reg;
    assign out_load  = state_reg == S_NET && (!out_valid || out_ready);

    assign sum_in  = (state_reg == S_LAST) ? dratio : ret_reg;
    assign sum_w   = 34'(realized_reg) + 34'(sum_in);
    assign sum_sat = (sum_w > 34'sd2147483647) ? $signed(S32_MAX)
                   : (sum_w < -34'sd2147483648) ? $signed(~S32_MAX) : sum_w[31:0];
    assign net_w   = 34'(ret_reg) - $signed({10'd0, cost_reg});
    assign net_sat = (net_w < -34'sd2147483648) ? $signed(~S32_MAX) : net_w[31:0];

    always_comb
    begin
        dcmd.start = 1'b0;
        dcmd.half  = half_flag_reg;
        dp8        = '0;
        unique case (dk_reg)
            D_GAP:  dp8 = LW'(open_reg) << 8;
            D_STOP: dp8 = stop_reg[LW-1:0];
            D_HALF: dp8 = half_reg;
            D_RUN:  dp8 = run_reg;
            default: dp8 = '0;
        endcase
        if (state_reg == S_LAST)
        begin
            dp8 = LW'(last_close_reg) << 8;
        end
        if (dk_reg == D_HALF)
        begin
            dcmd.half = 1'b1;
        end
        dcmd.start = (state_reg == S_DIV || (state_reg == S_LAST && time_exit))
                     && !dstat.busy;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dk_reg         <= D_GAP;
            stop_mult_reg  <= 16'd512;
            half_mult_reg  <= 16'd256;
            run_mult_reg   <= 16'd2048;
            cost_reg       <= 24'd117441;
            entry_reg      <= '0;
            stop_reg       <= '0;
            half_reg       <= '0;
            run_reg        <= '0;
            half_flag_reg  <= 1'b0;
            exit_flag_reg  <= 1'b0;
            close_seen_reg <= 1'b0;
            entry_bad_reg  <= 1'b0;
            realized_reg   <= '0;
            exit_ret_reg   <= '0;
            exit_code_reg  <= '0;
            last_close_reg <= '0;
            last_reg       <= 1'b0;
            out_valid      <= 1'b0;
            ret_reg        <= '0;
            res_ok_reg     <= 1'b0;
            kind_reg       <= EXIT_INVALID;
            net_return     <= '0;
            trade_valid    <= 1'b0;
            exit_kind      <= EXIT_INVALID;
            half_taken_out <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_STOP_MULT: stop_mult_reg <= cfg_data[15:0];
                    CFG_HALF_MULT: half_mult_reg <= cfg_data[15:0];
                    CFG_RUN_MULT:  run_mult_reg  <= cfg_data[15:0];
                    CFG_COST:      cost_reg      <= cfg_data;
                    default:       cost_reg      <= cost_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_bar;
                        open_reg  <= PW'(bar_open);
                        high_reg  <= PW'(bar_high);
                        low_reg   <= PW'(bar_low);
                        ook_reg   <= open_ok && close_ok;
                        hok_reg   <= high_ok && close_ok;
                        lok_reg   <= low_ok && close_ok;
                        dk_reg    <= close_ok ? D_GAP : D_RUN;
                        if (close_ok)
                        begin
                            last_close_reg <= PW'(bar_close);
                        end
                        else if (first_bar)
                        begin
                            last_close_reg <= '0;
                        end
                        if (first_bar)
                        begin
                            entry_reg      <= PW'(entry_price);
                            entry_bad_reg  <= PW'(entry_price) == '0
                                              || PW'(volatility) == '0;
                            risk_reg       <= (PW+16)'(stop_mult_reg)
                                              * (PW+16)'(PW'(volatility));
                            half_flag_reg  <= 1'b0;
                            exit_flag_reg  <= 1'b0;
                            close_seen_reg <= 1'b0;
                            realized_reg   <= '0;
                            exit_ret_reg   <= '0;
                            exit_code_reg  <= EXIT_GAP_STOP;
                            state_reg      <= S_TGT_H;
                        end
                        else
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_TGT_H:
                begin
                    stop_reg  <= ((LW+1)'(risk_reg) > (LW+1)'(e8)) ? '1
                                 : $signed((LW+1)'(e8) - (LW+1)'(risk_reg));
                    half_reg  <= tgt;
                    state_reg <= S_TGT_R;
                end
                S_TGT_R:
                begin
                    run_reg   <= tgt;
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= S_LAST;
                    if (!entry_bad_reg && entry_reg != '0 && !exit_flag_reg
                        && dk_reg == D_GAP)
                    begin
                        close_seen_reg <= 1'b1;
                        if (ook_reg && $signed((LW+1)'(LW'(open_reg) << 8)) <= stop_reg)
                        begin
                            dk_reg <= D_GAP;
                            state_reg <= S_DIV;
                        end
                        else if (lok_reg && $signed((LW+1)'(LW'(low_reg) << 8)) <= stop_reg)
                        begin
                            dk_reg <= D_STOP;
                            state_reg <= S_DIV;
                        end
                        else if (half_mult_reg != '0 && !half_flag_reg && hok_reg
                                 && (LW'(high_reg) << 8) >= half_reg)
                        begin
                            dk_reg <= D_HALF;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_RUNCHK;
                        end
                    end
                end
                S_RUNCHK:
                begin
                    if (hok_reg && (LW'(high_reg) << 8) >= run_reg)
                    begin
                        dk_reg    <= D_RUN;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (dstat.done)
                    begin
                        ret_reg <= dratio;
                        state_reg <= S_HALF;
                    end
                end
                S_HALF:
                begin
                    if (dk_reg == D_HALF)
                    begin
                        realized_reg  <= ret_reg[31:0];
                        half_flag_reg <= 1'b1;
                        stop_reg      <= $signed((LW+1)'(e8));
                        state_reg     <= S_RUNCHK;
                    end
                    else
                    begin
                        exit_ret_reg  <= sum_sat;
                        exit_flag_reg <= 1'b1;
                        unique case (dk_reg)
                            D_GAP:   exit_code_reg <= EXIT_GAP_STOP;
                            D_STOP:  exit_code_reg <= EXIT_STOP;
                            default: exit_code_reg <= EXIT_TARGET;
                        endcase
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_LAST;
                    dk_reg    <= D_RUN;
                end
                S_LAST:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (entry_bad_reg || entry_reg == '0
                             || !(exit_flag_reg || close_seen_reg))
                    begin
                        res_ok_reg <= 1'b0;
                        kind_reg   <= EXIT_INVALID;
                        state_reg  <= S_NET;
                    end
                    else if (exit_flag_reg)
                    begin
                        res_ok_reg <= 1'b1;
                        ret_reg    <= 33'(exit_ret_reg);
                        kind_reg   <= exit_code_reg;
                        state_reg  <= S_NET;
                    end
                    else if (dstat.done)
                    begin
                        res_ok_reg <= 1'b1;
                        ret_reg    <= 33'(sum_sat);
                        kind_reg   <= EXIT_TIME;
                        state_reg  <= S_NET;
                    end
                end
                S_NET:
                begin
                    if (out_load)
                    begin
                        net_return     <= res_ok_reg ? net_sat : '0;
                        trade_valid    <= res_ok_reg;
                        exit_kind      <= kind_reg;
                        half_taken_out <= res_ok_reg && half_flag_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end
endmodule

// ----- hdl/bete_ratio_div.sv -----
// Bit-serial unit that forms p8/(e*256) - 1, or half of it, as a saturated signed return.
module bete_ratio_div #(
    parameter int PRICE_WIDTH      = 32,
    parameter int RETURN_FRAC_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bete_pkg::div_cmd_t       cmd,
    input  logic [PRICE_WIDTH+8:0]   p8,
    input  logic [PRICE_WIDTH-1:0]   e,
    output bete_pkg::div_stat_t      stat,
    output logic signed [32:0]       ratio
);
    import bete_pkg::*;

    localparam int DW = PRICE_WIDTH + 9;
    localparam int WB = 31 - RETURN_FRAC_BITS;
    localparam int STEPS = DW + RETURN_FRAC_BITS;
    localparam int CW = $clog2(STEPS + 1);

    typedef enum logic [1:0] { S_IDLE, S_RUN, S_DONE } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW-1:0]   mag_reg;
    logic [STEPS-1:0] q_reg;
    logic            neg_reg;
    logic            half_reg;
    logic signed [32:0] ratio_reg;

    logic [DW-1:0]   den_w;
    logic [DW-1:0]   p_w;
    logic [DW:0]     shifted;
    logic            ge;
    logic [STEPS-1:0] q_fin;
    logic [31:0]     qmag;
    logic [31:0]     qh;

    assign den_w   = DW'(e) << 8;
    assign p_w     = DW'(p8);
    assign shifted = {rem_reg[DW-1:0], mag_reg[DW-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign q_fin   = q_reg;

    always_comb
    begin
        if (q_fin[STEPS-1:RETURN_FRAC_BITS] >> WB != '0)
        begin
            qmag = S32_MAX;
        end
        else
        begin
            qmag = 32'(q_fin);
        end
        qh = half_reg ? (qmag >> 1) : qmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        if (p_w >= den_w)
                        begin
                            mag_reg <= p_w - den_w;
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            mag_reg <= den_w - p_w;
                            neg_reg <= 1'b1;
                        end
                        den_reg   <= den_w;
                        half_reg  <= cmd.half;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (ge)
                    begin
                        rem_reg <= shifted - {1'b0, den_reg};
                    end
                    else
                    begin
                        rem_reg <= shifted;
                    end
                    q_reg   <= {q_reg[STEPS-2:0], ge};
                    mag_reg <= mag_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(STEPS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    ratio_reg <= neg_reg ? -$signed({1'b0, qh}) : $signed({1'b0, qh});
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = state_reg != S_IDLE;
    assign stat.done = state_reg == S_DONE;
    assign ratio     = stat.done
                       ? (neg_reg ? -$signed({1'b0, qh}) : $signed({1'b0, qh}))
                       : ratio_reg;
endmodule

// ----- tb/sv/bete_checker.sv -----
// Checker for the bracket exit trade evaluator: predicts results and compares them.
`timescale 1ns / 1ps

module bete_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        first_bar,
    input  logic        last_bar,
    input  logic [31:0] entry_price,
    input  logic [31:0] volatility,
    input  logic [31:0] bar_open,
    input  logic        open_ok,
    input  logic [31:0] bar_high,
    input  logic        high_ok,
    input  logic [31:0] bar_low,
    input  logic        low_ok,
    input  logic [31:0] bar_close,
    input  logic        close_ok,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic signed [31:0] net_return,
    input  logic        trade_valid,
    input  logic [2:0]  exit_kind,
    input  logic        half_taken_out,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          error_count,
    output int          pending_count
);
    import bete_pkg::*;

    typedef struct packed {
        logic signed [31:0] net;
        logic               valid;
        logic [2:0]         kind;
        logic               half;
    } trade_result_t;

    localparam longint LEVEL_CAP = 64'd1 << 40;
    localparam longint RET_MAX = 64'sd2147483647;
    localparam longint RET_MIN = -64'sd2147483648;

    trade_result_t expected_trades[$];

    longint unsigned stop_mult, half_mult, run_mult, cost;
    longint unsigned entry, half_lvl, run_lvl, last_close;
    longint stop_lvl, realized, exit_ret;
    logic half_flag, exited, close_seen, entry_bad;
    logic [2:0] exit_code;

    function automatic longint clamp32(longint v);
        if (v > RET_MAX) return RET_MAX;
        if (v < RET_MIN) return RET_MIN;
        return v;
    endfunction

    function automatic longint price_ratio(longint unsigned p8, longint unsigned e,
                                           logic halve);
        longint unsigned den, mag, whole, rem, q;
        logic neg;
        den = e << 8;
        neg = p8 < den;
        mag = neg ? den - p8 : p8 - den;
        whole = mag / den;
        rem = mag % den;
        if ((whole >> 7) != 0) begin
            q = 64'h7FFF_FFFF;
        end
        else begin
            q = whole << 24;
            for (int i = 23; i >= 0; i--) begin
                rem = rem << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | (64'd1 << i);
                end
            end
        end
        if (halve) q = q >> 1;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned target_at(longint unsigned e8,
                                                  longint unsigned mult,
                                                  longint unsigned risk);
        longint unsigned off;
        off = (mult * risk) >> 8;
        if (off >= LEVEL_CAP || e8 + off >= LEVEL_CAP) return LEVEL_CAP;
        return e8 + off;
    endfunction

    function automatic void close_trade(logic [2:0] code, longint part);
        exit_ret = clamp32(realized + part);
        exit_code = code;
        exited = 1'b1;
    endfunction

    task automatic evaluate_bar();
        longint unsigned e8, risk, o8, h8, l8;
        trade_result_t r;
        longint ret;
        o8 = longint'(bar_open) << 8;
        h8 = longint'(bar_high) << 8;
        l8 = longint'(bar_low) << 8;
        if (first_bar) begin
            e8 = longint'(entry_price) << 8;
            risk = stop_mult * volatility;
            entry = entry_price;
            entry_bad = (entry_price == 0) || (volatility == 0);
            stop_lvl = (risk > e8) ? -1 : longint'(e8 - risk);
            half_lvl = target_at(e8, half_mult, risk);
            run_lvl = target_at(e8, run_mult, risk);
            half_flag = 0;
            exited = 0;
            close_seen = 0;
            realized = 0;
            exit_ret = 0;
            exit_code = EXIT_GAP_STOP;
            last_close = 0;
        end
        if (!entry_bad && entry != 0 && !exited && close_ok) begin
            last_close = bar_close;
            close_seen = 1;
            if (open_ok && longint'(o8) <= stop_lvl) begin
                close_trade(EXIT_GAP_STOP, price_ratio(o8, entry, half_flag));
            end
            else if (low_ok && longint'(l8) <= stop_lvl) begin
                close_trade(EXIT_STOP, price_ratio(stop_lvl, entry, half_flag));
            end
            else begin
                if (half_mult != 0 && !half_flag && high_ok && h8 >= half_lvl) begin
                    realized = price_ratio(half_lvl, entry, 1'b1);
                    half_flag = 1;
                    stop_lvl = longint'(entry << 8);
                end
                if (high_ok && h8 >= run_lvl)
                    close_trade(EXIT_TARGET, price_ratio(run_lvl, entry, half_flag));
            end
        end
        if (last_bar) begin
            r.valid = !entry_bad && entry != 0 && (exited || close_seen);
            r.net = 0;
            r.kind = EXIT_INVALID;
            r.half = r.valid && half_flag;
            if (r.valid) begin
                if (exited) begin
                    ret = exit_ret;
                    r.kind = exit_code;
                end
                else begin
                    ret = clamp32(realized + price_ratio(last_close << 8, entry, half_flag));
                    r.kind = EXIT_TIME;
                end
                r.net = clamp32(ret - longint'(cost));
            end
            expected_trades.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        trade_result_t want;
        trade_result_t got;
        if (!rst_n) begin
            stop_mult = 512;
            half_mult = 256;
            run_mult = 2048;
            cost = 117441;
            entry = 0; stop_lvl = 0; half_lvl = 0; run_lvl = 0;
            half_flag = 0; exited = 0; close_seen = 0; entry_bad = 0;
            realized = 0; exit_ret = 0; exit_code = EXIT_GAP_STOP; last_close = 0;
            error_count <= 0;
            pending_count <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STOP_MULT: stop_mult = cfg_data[15:0];
                    CFG_HALF_MULT: half_mult = cfg_data[15:0];
                    CFG_RUN_MULT:  run_mult = cfg_data[15:0];
                    default:       cost = cfg_data;
                endcase
            end
            if (in_valid && in_ready) evaluate_bar();
            if (out_valid && out_ready) begin
                got = '{net_return, trade_valid, exit_kind, half_taken_out};
                if (expected_trades.size() == 0) begin
                    if (error_count < 10)
                        $display("Unexpected result %h at %0t", got, $realtime);
                    error_count <= error_count + 1;
                end
                else begin
                    want = expected_trades.pop_front();
                    if (want !== got) begin
                        if (error_count < 10)
                            $display({"Mismatch: expected net %0d valid %b kind %0d half %b,",
                                      " got net %0d valid %b kind %0d half %b"},
                                     want.net, want.valid, want.kind, want.half,
                                     got.net, got.valid, got.kind, got.half);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_count <= expected_trades.size();
        end
    end

endmodule

// ----- tb/sv/tb_bracket_exit_trade_evaluator.sv -----
// Testbench top for the bracket exit trade evaluator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_bracket_exit_trade_evaluator;
    import bete_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, first_bar = 0, last_bar = 0;
    logic [31:0] entry_price = 0, volatility = 0, bar_open = 0, bar_high = 0;
    logic [31:0] bar_low = 0, bar_close = 0;
    logic open_ok = 0, high_ok = 0, low_ok = 0, close_ok = 0;
    logic in_ready, out_valid, trade_valid, half_taken_out, cfg_ready;
    logic out_ready = 0;
    logic signed [31:0] net_return;
    logic [2:0] exit_kind;
    logic cfg_valid = 0;
    logic [1:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    int error_count, pending_count;
    int idle_cycles;
    int stall_left;
    logic [31:0] base_price, base_vol;

    always #4 clk = ~clk;

    bracket_exit_trade_evaluator dut (.*);
    bete_checker checker_i (.*);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready) begin
            stall_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            out_ready <= 0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 0;
        end
        else begin
            out_ready <= 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_bar(logic fb, logic lb, logic [31:0] e, logic [31:0] v,
                            logic [31:0] o, logic ook, logic [31:0] h, logic hok,
                            logic [31:0] l, logic lok, logic [31:0] c, logic cok,
                            logic paced);
        int gap;
        gap = paced ? $urandom_range(0, 15) : 0;
        repeat (gap) @(posedge clk);
        in_valid <= 1;
        first_bar <= fb; last_bar <= lb;
        entry_price <= e; volatility <= v;
        bar_open <= o; open_ok <= ook;
        bar_high <= h; high_ok <= hok;
        bar_low <= l; low_ok <= lok;
        bar_close <= c; close_ok <= cok;
        do @(posedge clk); while (!in_ready);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [31:0] near_price(logic [31:0] p, logic [31:0] spread);
        return p - spread + $urandom_range(0, 2 * spread);
    endfunction

    task automatic random_trade(int bars);
        logic [31:0] o, h, l, c, sp;
        sp = base_vol * 3 + 1;
        send_bar(1, bars == 1, base_price, base_vol, near_price(base_price, sp),
                 $urandom_range(0, 7) != 0, near_price(base_price, sp),
                 $urandom_range(0, 7) != 0, near_price(base_price, sp),
                 $urandom_range(0, 7) != 0, near_price(base_price, sp),
                 $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
        for (int b = 1; b < bars; b++) begin
            c = near_price(base_price, sp);
            o = near_price(base_price, sp);
            h = (o > c ? o : c) + $urandom_range(0, base_vol * 2);
            l = (o < c ? o : c) - $urandom_range(0, base_vol * 2);
            send_bar(0, b == bars - 1, $urandom, $urandom, o, $urandom_range(0, 9) != 0,
                     h, $urandom_range(0, 9) != 0, l, $urandom_range(0, 9) != 0, c,
                     $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        int sent;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, invalid entries, one-bar trades, skipped bars.
        send_bar(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_bar(1, 1, 0, 100, 90, 1, 110, 1, 80, 1, 100, 1, 1);
        send_bar(1, 1, 1000, 0, 990, 1, 1010, 1, 980, 1, 1000, 1, 1);
        send_bar(1, 0, 1000, 10, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_bar(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_bar(1, 0, 1000, 10, 1000, 1, 1005, 1, 995, 1, 1000, 1, 1);
        send_bar(0, 0, 0, 0, 970, 1, 1000, 1, 960, 1, 980, 1, 1);
        send_bar(0, 1, 0, 0, 1000, 1, 1500, 1, 900, 1, 1000, 1, 1);
        send_bar(1, 0, 1000, 10, 1000, 1, 1012, 1, 995, 1, 1010, 1, 1);
        send_bar(0, 0, 0, 0, 1010, 1, 1011, 1, 999, 1, 1005, 1, 1);
        send_bar(0, 1, 0, 0, 1010, 0, 1100, 1, 1000, 1, 1050, 1, 1);
        send_bar(0, 1, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1);
        send_bar(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1);
        send_bar(1, 1, 1, 1, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1,
                 32'hFFFF_FFFF, 1, 1);
        send_bar(1, 1, 32'hFFFF_FFFF, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1);
        send_bar(1, 1, 1000, 10, 1000, 1, 1001, 1, 1000, 1, 1000, 1, 1);
        // Stall the sender until every result is back.
        drain();

        write_reg(CFG_STOP_MULT, 24'hFFFF);
        write_reg(CFG_HALF_MULT, 0);
        write_reg(CFG_RUN_MULT, 0);
        write_reg(CFG_COST, 24'hFFFFFF);
        send_bar(1, 1, 5000, 3, 5000, 1, 5000, 1, 4990, 1, 5001, 1, 1);
        send_bar(1, 0, 5000, 32'hFFFF_FFFF, 5000, 1, 4999, 1, 1, 1, 10, 1, 1);
        send_bar(0, 1, 0, 0, 0, 1, 0, 1, 0, 1, 0, 1, 1);
        drain();

        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_STOP_MULT, phase == 5 ? 24'hFFFF : $urandom_range(1, 1024));
            write_reg(CFG_HALF_MULT, phase == 2 ? 0 : (phase == 5 ? 24'hFFFF
                                                                  : $urandom_range(0, 1024)));
            write_reg(CFG_RUN_MULT, phase == 3 ? 0 : (phase == 5 ? 24'hFFFF
                                                                 : $urandom_range(128, 4096)));
            write_reg(CFG_COST, phase == 4 ? 0 : $urandom_range(0, 24'hFFFFFF));
            while (sent < 275 * (phase + 1)) begin
                int bars;
                bars = $urandom_range(1, 10);
                base_price = $urandom_range(0, 15) == 0 ? $urandom
                                                          : $urandom_range(100, 1000000);
                base_vol = $urandom_range(0, 31) == 0 ? 0 : $urandom_range(1, base_price / 64 + 1);
                if ($urandom_range(0, 9) == 0) begin
                    bars = 1;
                    send_bar(0, $urandom_range(0, 1), $urandom, $urandom, $urandom,
                             $urandom_range(0, 1), $urandom, $urandom_range(0, 1),
                             $urandom, $urandom_range(0, 1), $urandom,
                             $urandom_range(0, 1), 1);
                end
                else
                    random_trade(bars);
                sent += bars;
            end
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
